[rtl/pscm_pkg.sv]
// Package for the p-code stack machine step unit.
// Holds stack sizing, instruction and ALU codes, status codes and output packing.
// No dependencies.
`default_nettype none
package pscm_pkg;

  // Data stack sizing
  localparam int STACK_DEPTH = 1024;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int WORD_W      = 64;

  // Instruction kinds
  typedef enum logic [3:0] {
    OP_LIT = 4'd0,
    OP_OPR = 4'd1,
    OP_LOD = 4'd2,
    OP_STO = 4'd3,
    OP_LEV = 4'd4,
    OP_RET = 4'd5,
    OP_INT = 4'd6,
    OP_JMP = 4'd7,
    OP_JPC = 4'd8
  } op_e;

  // ALU sub-operations
  localparam logic [31:0] ALU_NEG  = 32'd0;
  localparam logic [31:0] ALU_ADD  = 32'd1;
  localparam logic [31:0] ALU_SUB  = 32'd2;
  localparam logic [31:0] ALU_MUL  = 32'd3;
  localparam logic [31:0] ALU_DIV  = 32'd4;
  localparam logic [31:0] ALU_MOD  = 32'd5;
  localparam logic [31:0] ALU_EQ   = 32'd6;
  localparam logic [31:0] ALU_NEQ  = 32'd7;
  localparam logic [31:0] ALU_LT   = 32'd8;
  localparam logic [31:0] ALU_GT   = 32'd9;
  localparam logic [31:0] ALU_GE   = 32'd10;
  localparam logic [31:0] ALU_LE   = 32'd11;
  localparam logic [31:0] ALU_LOR  = 32'd12;
  localparam logic [31:0] ALU_OR   = 32'd13;
  localparam logic [31:0] ALU_LAND = 32'd14;
  localparam logic [31:0] ALU_AND  = 32'd15;
  localparam logic [31:0] ALU_XOR  = 32'd16;
  localparam logic [31:0] ALU_NOT  = 32'd17;
  localparam logic [31:0] ALU_WRT  = 32'd18;
  localparam logic [31:0] ALU_NL   = 32'd19;
  localparam logic [31:0] ALU_RD   = 32'd20;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Result packing in m_axis_tdata
  localparam int OUT_NPC_LSB   = 0;
  localparam int OUT_WVALID    = 32;
  localparam int OUT_WVAL_LSB  = 33;
  localparam int OUT_NL        = 97;
  localparam int OUT_HALT      = 98;
  localparam int OUT_ST_LSB    = 99;
  localparam int OUT_W         = 104;
  localparam int IN_W          = 136;

endpackage
`default_nettype wire

[rtl/pcode_stack_machine_step_unit.sv]
// P-code stack machine step unit: executes one instruction per transaction.
// Depends on pscm_pkg and pscm_ram.
//
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tuser: operation; tdata: level, operand, pc, read
// m_axis   out  m_axis_tvalid/tready       tdata: next_pc, write_valid, write_value,
//                                          newline, halted, status
//
// Multiply, divide and mod run in the one-bit-per-cycle shared add/subtract unit; lod
// and sto follow one frame link per frame level. Each stack read goes through the
// single read port of the RAM.
// Reset: a clearing pass zeroes all STACK_DEPTH (1024) stack words; no input
// is accepted until it ends. A result waits in the output register while the next
// instruction is accepted; the unit stalls at its end until that register is free.
`default_nettype none
module pcode_stack_machine_step_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [3:0]   s_axis_tuser_i,  // operation
  input  wire logic [135:0] s_axis_tdata_i,  // level[3:0], operand[35:4], pc[67:36],
                                             // read_value[131:68], zero pad
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [103:0]      m_axis_tdata_o   // next_pc[31:0], write_valid[32],
                                             // write_value[96:33], newline[97],
                                             // halted[98], status[100:99], zero pad
);

  localparam int IW = pscm_pkg::IDX_W;
  localparam int WW = pscm_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_WALK, S_LINK, S_LODR, S_STOR, S_LEVR,
    S_TOP, S_SEC, S_ITER, S_FIX, S_WB, S_DONE
  } state_e;

  state_e          state_q;
  logic [IW-1:0]   clr_q;
  logic [IW-1:0]   top_q, fb_q;
  logic [3:0]      op_q, cnt_q;
  logic [31:0]     opd_q;
  logic [WW-1:0]   rd_q;
  logic [IW-1:0]   base_q, addr_q;
  logic [WW-1:0]   a_q, b_q, res_q;
  logic [WW:0]     x_q;
  logic [WW-1:0]   y_q, z_q;
  logic [5:0]      iter_q;
  logic [31:0]     nxt_q;
  logic [WW-1:0]   wval_q;
  logic            wvalid_q, nl_q, halt_q;
  logic [1:0]      st_q;
  logic            ovalid_q;
  logic [pscm_pkg::OUT_W-1:0] odata_q;

  // RAM ports
  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  logic [WW-1:0]   ram_wdata, ram_rdata;

  pscm_ram #(.WIDTH(WW), .DEPTH(pscm_pkg::STACK_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // range checks
  logic          push_ok, pop_ok, int_ok, addr_ok, link_ok;
  logic [32:0]   walk_sum, int_sum;
  logic [IW-1:0] top_inc, top_dec;
  assign top_inc  = top_q + IW'(1);
  assign top_dec  = top_q - IW'(1);
  assign push_ok  = ((IW+1)'(top_q) + (IW+1)'(1)) < (IW+1)'(pscm_pkg::STACK_DEPTH);
  assign pop_ok   = (top_q != '0);
  assign int_sum  = 33'(top_q) + 33'd1 + 33'(opd_q);
  assign int_ok   = push_ok && (int_sum < 33'(pscm_pkg::STACK_DEPTH));
  assign walk_sum = 33'(base_q) + 33'(opd_q);
  assign addr_ok  = walk_sum < 33'(pscm_pkg::STACK_DEPTH);
  assign link_ok  = ram_rdata < WW'(pscm_pkg::STACK_DEPTH);

  // combinational ALU ops, a from RAM, b held
  logic [WW-1:0] alu_r;
  logic          s_lt, s_gt;
  assign s_lt = $signed(ram_rdata) < $signed(b_q);
  assign s_gt = $signed(ram_rdata) > $signed(b_q);
  always_comb begin
    alu_r = '0;
    unique case (opd_q)
      pscm_pkg::ALU_ADD:  alu_r = ram_rdata + b_q;
      pscm_pkg::ALU_SUB:  alu_r = ram_rdata - b_q;
      pscm_pkg::ALU_EQ:   alu_r = WW'(ram_rdata == b_q);
      pscm_pkg::ALU_NEQ:  alu_r = WW'(ram_rdata != b_q);
      pscm_pkg::ALU_LT:   alu_r = WW'(s_lt);
      pscm_pkg::ALU_GT:   alu_r = WW'(s_gt);
      pscm_pkg::ALU_GE:   alu_r = WW'(!s_lt);
      pscm_pkg::ALU_LE:   alu_r = WW'(!s_gt);
      pscm_pkg::ALU_LOR,
      pscm_pkg::ALU_OR:   alu_r = ram_rdata | b_q;
      pscm_pkg::ALU_LAND,
      pscm_pkg::ALU_AND:  alu_r = ram_rdata & b_q;
      default:            alu_r = ram_rdata ^ b_q;
    endcase
  end

  // shared add/subtract unit: multiply accumulates, divide trial-subtracts
  logic          is_mul;
  logic [WW:0]   div_sh, opa, opb;
  logic [WW+1:0] sum;
  assign is_mul = (opd_q == pscm_pkg::ALU_MUL);
  assign div_sh = {x_q[WW-1:0], y_q[WW-1]};
  assign opa    = is_mul ? {1'b0, x_q[WW-1:0]} : div_sh;
  assign opb    = is_mul ? {1'b0, (z_q[0] ? y_q : '0)} : ~{1'b0, z_q};
  assign sum    = {1'b0, opa} + {1'b0, opb} + (WW+2)'(!is_mul);

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = top_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      S_DEC: begin
        if (op_q == pscm_pkg::OP_LEV) ram_raddr = fb_q;
        if (op_q == pscm_pkg::OP_LIT && push_ok) begin
          ram_we    = 1'b1;
          ram_waddr = top_inc;
          ram_wdata = WW'(opd_q);
        end else if (op_q == pscm_pkg::OP_OPR && opd_q == pscm_pkg::ALU_RD) begin
          ram_we    = 1'b1;
          ram_waddr = top_q;
          ram_wdata = rd_q;
        end else if (op_q == pscm_pkg::OP_INT && int_ok) begin
          ram_we    = 1'b1;
          ram_waddr = top_inc;
          ram_wdata = WW'(fb_q);
        end
      end
      S_WALK: begin
        if (cnt_q != '0) ram_raddr = base_q;
        else if (op_q == pscm_pkg::OP_LOD) ram_raddr = walk_sum[IW-1:0];
        else ram_raddr = top_q;
      end
      S_LODR: begin
        ram_we    = 1'b1;
        ram_waddr = top_inc;
        ram_wdata = ram_rdata;
      end
      S_STOR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = ram_rdata;
      end
      S_TOP: begin
        ram_raddr = top_dec;
        if (op_q == pscm_pkg::OP_OPR && opd_q == pscm_pkg::ALU_NEG) begin
          ram_we    = 1'b1;
          ram_waddr = top_q;
          ram_wdata = '0 - ram_rdata;
        end else if (op_q == pscm_pkg::OP_OPR && opd_q == pscm_pkg::ALU_NOT) begin
          ram_we    = 1'b1;
          ram_waddr = top_q;
          ram_wdata = WW'(ram_rdata == '0);
        end
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = top_dec;
        ram_wdata = res_q;
      end
      default: ;
    endcase
  end

  // sequencer, stack pointers and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      top_q    <= '0;
      fb_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (ovalid_q && m_axis_tready_i && state_q != S_DONE) ovalid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == IW'(pscm_pkg::STACK_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q     <= s_axis_tuser_i;
            cnt_q    <= s_axis_tdata_i[3:0];
            opd_q    <= s_axis_tdata_i[35:4];
            rd_q     <= s_axis_tdata_i[131:68];
            nxt_q    <= s_axis_tdata_i[67:36] + 32'd1;
            wval_q   <= '0;
            wvalid_q <= 1'b0;
            nl_q     <= 1'b0;
            halt_q   <= 1'b0;
            st_q     <= pscm_pkg::ST_OK;
            base_q   <= fb_q;
            state_q  <= S_DEC;
          end
        end
        S_DEC: begin
          state_q <= S_DONE;
          unique case (op_q)
            pscm_pkg::OP_LIT: begin
              if (push_ok) top_q <= top_inc;
              else st_q <= pscm_pkg::ST_RANGE;
            end
            pscm_pkg::OP_OPR: begin
              if (opd_q == pscm_pkg::ALU_NEG || opd_q == pscm_pkg::ALU_NOT) begin
                state_q <= S_TOP;
              end else if (opd_q == pscm_pkg::ALU_NL) begin
                nl_q <= 1'b1;
              end else if (opd_q == pscm_pkg::ALU_WRT || opd_q <= pscm_pkg::ALU_XOR) begin
                if (pop_ok) state_q <= S_TOP;
                else st_q <= pscm_pkg::ST_RANGE;
              end
            end
            pscm_pkg::OP_LOD: begin
              if (push_ok) state_q <= S_WALK;
              else st_q <= pscm_pkg::ST_RANGE;
            end
            pscm_pkg::OP_STO: begin
              if (pop_ok) state_q <= S_WALK;
              else st_q <= pscm_pkg::ST_RANGE;
            end
            pscm_pkg::OP_LEV: begin
              if (fb_q != '0) state_q <= S_LEVR;
              else st_q <= pscm_pkg::ST_RANGE;
            end
            pscm_pkg::OP_RET: begin
              nxt_q  <= '0;
              halt_q <= 1'b1;
            end
            pscm_pkg::OP_INT: begin
              if (int_ok) begin
                fb_q  <= top_inc;
                top_q <= int_sum[IW-1:0];
              end else begin
                st_q <= pscm_pkg::ST_RANGE;
              end
            end
            pscm_pkg::OP_JMP: nxt_q <= opd_q;
            pscm_pkg::OP_JPC: begin
              if (pop_ok) state_q <= S_TOP;
              else st_q <= pscm_pkg::ST_RANGE;
            end
            default: ;
          endcase
        end
        // follow one frame link per level through S_WALK and S_LINK, then form the address
        S_WALK: begin
          if (cnt_q != '0) begin
            state_q <= S_LINK;
          end else if (addr_ok) begin
            addr_q  <= walk_sum[IW-1:0];
            state_q <= (op_q == pscm_pkg::OP_LOD) ? S_LODR : S_STOR;
          end else begin
            st_q    <= pscm_pkg::ST_RANGE;
            state_q <= S_DONE;
          end
        end
        S_LINK: begin
          if (link_ok) begin
            base_q  <= ram_rdata[IW-1:0];
            cnt_q   <= cnt_q - 4'd1;
            state_q <= S_WALK;
          end else begin
            st_q    <= pscm_pkg::ST_RANGE;
            state_q <= S_DONE;
          end
        end
        S_LODR: begin
          top_q   <= top_inc;
          state_q <= S_DONE;
        end
        S_STOR: begin
          top_q   <= top_dec;
          state_q <= S_DONE;
        end
        S_LEVR: begin
          if (link_ok) begin
            top_q <= fb_q - IW'(1);
            fb_q  <= ram_rdata[IW-1:0];
          end else begin
            st_q <= pscm_pkg::ST_RANGE;
          end
          state_q <= S_DONE;
        end
        // top of stack available
        S_TOP: begin
          b_q     <= ram_rdata;
          state_q <= S_DONE;
          if (op_q == pscm_pkg::OP_JPC) begin
            if (ram_rdata == '0) nxt_q <= opd_q;
            top_q <= top_dec;
          end else if (opd_q == pscm_pkg::ALU_WRT) begin
            wval_q   <= ram_rdata;
            wvalid_q <= 1'b1;
            nl_q     <= 1'b1;
            top_q    <= top_dec;
          end else if (opd_q != pscm_pkg::ALU_NEG && opd_q != pscm_pkg::ALU_NOT) begin
            state_q <= S_SEC;
          end
        end
        // second operand available
        S_SEC: begin
          a_q    <= ram_rdata;
          iter_q <= '0;
          x_q    <= '0;
          if (is_mul) begin
            y_q     <= ram_rdata;
            z_q     <= b_q;
            state_q <= S_ITER;
          end else if (opd_q == pscm_pkg::ALU_DIV || opd_q == pscm_pkg::ALU_MOD) begin
            if (b_q == '0) begin
              res_q   <= '0;
              st_q    <= pscm_pkg::ST_DIV0;
              state_q <= S_WB;
            end else begin
              y_q     <= ram_rdata[WW-1] ? ('0 - ram_rdata) : ram_rdata;
              z_q     <= b_q[WW-1] ? ('0 - b_q) : b_q;
              state_q <= S_ITER;
            end
          end else begin
            res_q   <= alu_r;
            state_q <= S_WB;
          end
        end
        S_ITER: begin
          iter_q <= iter_q + 6'd1;
          if (is_mul) begin
            x_q <= {1'b0, sum[WW-1:0]};
            y_q <= {y_q[WW-2:0], 1'b0};
            z_q <= {1'b0, z_q[WW-1:1]};
          end else begin
            x_q <= sum[WW+1] ? sum[WW:0] : div_sh;
            y_q <= {y_q[WW-2:0], sum[WW+1]};
          end
          if (iter_q == 6'd63) state_q <= S_FIX;
        end
        // multiply result, or sign correction of quotient or remainder
        S_FIX: begin
          if (is_mul) res_q <= x_q[WW-1:0];
          else if (opd_q == pscm_pkg::ALU_DIV)
            res_q <= (a_q[WW-1] ^ b_q[WW-1]) ? ('0 - y_q) : y_q;
          else
            res_q <= a_q[WW-1] ? ('0 - x_q[WW-1:0]) : x_q[WW-1:0];
          state_q <= S_WB;
        end
        S_WB: begin
          top_q   <= top_dec;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!ovalid_q || m_axis_tready_i) begin
            odata_q  <= {3'b000, st_q, halt_q, nl_q, wval_q, wvalid_q, nxt_q};
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule
`default_nettype wire

[rtl/pscm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pscm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/pscm_checker.sv]
// Port-level checker for the p-code stack machine step unit, bound to the top.
// Depends on pscm_pkg.
`default_nettype none
module pscm_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic [3:0]   s_axis_tuser_i,
  input wire logic [135:0] s_axis_tdata_i,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [103:0] m_axis_tdata_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // busy right after an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after accept");

  // halt always returns to address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[pscm_pkg::OUT_HALT] |->
      m_axis_tdata_o[31:0] == 32'd0)
    else $error("halt with nonzero next pc");

  // an error never comes with a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[100:99] != pscm_pkg::ST_OK |->
      !m_axis_tdata_o[pscm_pkg::OUT_WVALID])
    else $error("write reported with error status");

endmodule

bind pcode_stack_machine_step_unit pscm_checker u_pscm_checker (.*);
`default_nettype wire

[bench/tb_pcode_stack_machine_step_unit.sv]
// Testbench for the p-code stack machine step unit: directed corner cases, then random
// instruction streams checked against a scoreboard that mirrors the stack machine.
// Depends on pscm_pkg and the RTL of pcode_stack_machine_step_unit.
`timescale 1ns / 1ps
module tb_pcode_stack_machine_step_unit;
  import pscm_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int HoldCycles = 400;

  typedef struct {
    logic [31:0] next_pc;
    logic        write_valid;
    logic [63:0] write_value;
    logic        newline;
    logic        halted;
    logic [1:0]  status;
  } step_result_t;

  // Scoreboard: machine state mirror plus queue of pending step results
  class step_scoreboard;
    logic [63:0]  stack_mem [STACK_DEPTH];
    int unsigned  top;
    int unsigned  base;
    step_result_t pending_q[$];
    int           mismatches;

    function new();
      foreach (stack_mem[i]) stack_mem[i] = '0;
      top = 0;
      base = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endtask

    // Follow frame links; 0 when a link leaves the stack
    function bit follow_links(logic [3:0] lvl, output int unsigned found);
      int unsigned b;
      b = base;
      for (int i = 0; i < lvl; i++) begin
        if (stack_mem[b] >= STACK_DEPTH) return 0;
        b = stack_mem[b][IDX_W-1:0];
      end
      found = b;
      return 1;
    endfunction

    function logic [63:0] alu_binary(logic [31:0] sub, logic [63:0] a, logic [63:0] b,
                                     ref logic [1:0] st);
      logic [63:0] q;
      logic [63:0] ma;
      logic [63:0] mb;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      case (sub)
        ALU_ADD: return a + b;
        ALU_SUB: return a - b;
        ALU_MUL: return a * b;
        ALU_DIV, ALU_MOD: begin
          if (b == 0) begin
            st = ST_DIV0;
            return '0;
          end
          if (sub == ALU_DIV) begin
            q = ma / mb;
            return (a[63] ^ b[63]) ? -q : q;
          end
          q = ma % mb;
          return a[63] ? -q : q;
        end
        ALU_EQ:  return 64'(a == b);
        ALU_NEQ: return 64'(a != b);
        ALU_LT:  return 64'($signed(a) < $signed(b));
        ALU_GT:  return 64'($signed(b) < $signed(a));
        ALU_GE:  return 64'(!($signed(a) < $signed(b)));
        ALU_LE:  return 64'(!($signed(b) < $signed(a)));
        ALU_LOR, ALU_OR: return a | b;
        ALU_LAND, ALU_AND: return a & b;
        default: return a ^ b;
      endcase
    endfunction

    // Execute one accepted instruction and queue its result
    function void note_instruction(logic [3:0] op, logic [3:0] lvl, logic [31:0] opd,
                                   logic [31:0] pc, logic [63:0] rd);
      step_result_t r;
      int unsigned  t;
      int unsigned  fb;
      longint unsigned addr;
      logic [1:0]   st;
      t = top;
      st = ST_OK;
      r = '{next_pc: pc + 32'd1, write_valid: 0, write_value: '0, newline: 0,
            halted: 0, status: ST_OK};
      case (op)
        OP_LIT: begin
          if (t + 1 >= STACK_DEPTH) st = ST_RANGE;
          else begin
            top = t + 1;
            stack_mem[top] = {32'd0, opd};
          end
        end
        OP_OPR: begin
          if (opd == ALU_NEG) stack_mem[t] = -stack_mem[t];
          else if (opd == ALU_NOT) stack_mem[t] = (stack_mem[t] == 0) ? 64'd1 : 64'd0;
          else if (opd == ALU_WRT) begin
            if (t < 1) st = ST_RANGE;
            else begin
              r.write_value = stack_mem[t];
              r.write_valid = 1;
              r.newline = 1;
              top = t - 1;
            end
          end else if (opd == ALU_NL) r.newline = 1;
          else if (opd == ALU_RD) stack_mem[t] = rd;
          else if (opd <= ALU_XOR) begin
            if (t < 1) st = ST_RANGE;
            else begin
              stack_mem[t-1] = alu_binary(opd, stack_mem[t-1], stack_mem[t], st);
              top = t - 1;
            end
          end
        end
        OP_LOD: begin
          if (t + 1 >= STACK_DEPTH || !follow_links(lvl, fb)) st = ST_RANGE;
          else begin
            addr = longint'(fb) + opd;
            if (addr >= STACK_DEPTH) st = ST_RANGE;
            else begin
              stack_mem[t+1] = stack_mem[addr];
              top = t + 1;
            end
          end
        end
        OP_STO: begin
          if (t < 1 || !follow_links(lvl, fb)) st = ST_RANGE;
          else begin
            addr = longint'(fb) + opd;
            if (addr >= STACK_DEPTH) st = ST_RANGE;
            else begin
              stack_mem[addr] = stack_mem[t];
              top = t - 1;
            end
          end
        end
        OP_LEV: begin
          if (base == 0 || stack_mem[base] >= STACK_DEPTH) st = ST_RANGE;
          else begin
            top = base - 1;
            base = stack_mem[base][IDX_W-1:0];
          end
        end
        OP_RET: begin
          r.next_pc = '0;
          r.halted = 1;
        end
        OP_INT: begin
          if (longint'(t) + 1 + opd >= STACK_DEPTH) st = ST_RANGE;
          else begin
            stack_mem[t+1] = 64'(base);
            base = t + 1;
            top = t + 1 + opd;
          end
        end
        OP_JMP: r.next_pc = opd;
        OP_JPC: begin
          if (t < 1) st = ST_RANGE;
          else begin
            if (stack_mem[t] == 0) r.next_pc = opd;
            top = t - 1;
          end
        end
        default: ;
      endcase
      r.status = st;
      pending_q.push_back(r);
    endfunction

    // Compare one output transaction with the oldest expectation
    task check_result(logic [OUT_W-1:0] d);
      step_result_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      e = pending_q.pop_front();
      if (d[OUT_NPC_LSB +: 32] !== e.next_pc)
        report($sformatf("next_pc %h, expected %h", d[OUT_NPC_LSB +: 32], e.next_pc));
      if (d[OUT_WVALID] !== e.write_valid)
        report($sformatf("write_valid %b, expected %b", d[OUT_WVALID], e.write_valid));
      if (d[OUT_WVAL_LSB +: 64] !== e.write_value)
        report($sformatf("write_value %h, expected %h", d[OUT_WVAL_LSB +: 64],
                         e.write_value));
      if (d[OUT_NL] !== e.newline)
        report($sformatf("newline %b, expected %b", d[OUT_NL], e.newline));
      if (d[OUT_HALT] !== e.halted)
        report($sformatf("halted %b, expected %b", d[OUT_HALT], e.halted));
      if (d[OUT_ST_LSB +: 2] !== e.status)
        report($sformatf("status %0d, expected %0d", d[OUT_ST_LSB +: 2], e.status));
    endtask
  endclass

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             s_axis_tvalid_i = 0;
  logic             s_axis_tready_o;
  logic [3:0]       s_axis_tuser_i = '0;
  logic [IN_W-1:0]  s_axis_tdata_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  step_scoreboard sb = new();
  bit             no_idle = 0;
  bit             hold_req = 0;
  int             idle_cycles = 0;

  pcode_stack_machine_step_unit dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tuser_i,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always #2 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one instruction and wait for its transaction
  task send(logic [3:0] op, logic [3:0] lvl, logic [31:0] opd, logic [31:0] pc,
            logic [63:0] rd);
    int gap;
    s_axis_tuser_i = op;
    s_axis_tdata_i = {4'd0, rd, pc, opd, lvl};
    s_axis_tvalid_i = 1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_instruction(op, lvl, opd, pc, rd);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i = 0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task send_simple(logic [3:0] op, logic [31:0] opd);
    send(op, 4'd0, opd, $urandom, {$urandom, $urandom});
  endtask

  task send_read(logic [63:0] rd);
    send(OP_OPR, 4'd0, ALU_RD, $urandom, rd);
  endtask

  // Hold off until every expected result has come
  task drain();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // One random instruction, biased toward programs that stay inside the stack
  task send_random();
    int          r;
    logic [31:0] opd;
    logic [3:0]  lvl;
    r = $urandom_range(0, 99);
    if (sb.top > 60 && r < 50) r = 30;
    lvl = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    opd = $urandom_range(0, 8);
    if (r < 25) begin
      opd = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
      send_simple(OP_LIT, opd);
    end else if (r < 50) begin
      opd = (r == 30 && sb.top > 60) ? ALU_ADD : $urandom_range(0, 21);
      if ($urandom_range(0, 30) == 0) opd = $urandom;
      send(OP_OPR, lvl, opd, $urandom, {$urandom, $urandom});
    end else if (r < 60) send(OP_LOD, lvl, opd, $urandom, {$urandom, $urandom});
    else if (r < 70) send(OP_STO, lvl, opd, $urandom, {$urandom, $urandom});
    else if (r < 76) send_simple(OP_INT, $urandom_range(0, 6));
    else if (r < 82) send_simple(OP_LEV, $urandom);
    else if (r < 87) send_simple(OP_JMP, $urandom);
    else if (r < 94) send_simple(OP_JPC, $urandom);
    else if (r < 96) send_simple(OP_RET, $urandom);
    else if (r < 98) send_simple(4'($urandom_range(9, 15)), $urandom);
    else send(4'($urandom), 4'($urandom), $urandom, $urandom, {$urandom, $urandom});
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready_i = 0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready_i = 0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1;

    // Stack underflow and empty-frame cases
    send_simple(OP_LEV, 0);
    send(OP_STO, 4'd0, 0, 32'hFFFF_FFFF, '0);
    send_simple(OP_OPR, ALU_ADD);
    send_simple(OP_OPR, ALU_WRT);
    send_simple(OP_JPC, 5);
    // Divide by zero, then most negative over minus one for div and mod
    send_simple(OP_LIT, 32'hFFFF_FFFF);
    send_simple(OP_LIT, 0);
    send_simple(OP_OPR, ALU_DIV);
    send_read(64'h8000_0000_0000_0000);
    send_simple(OP_LIT, 1);
    send_simple(OP_OPR, ALU_NEG);
    send_simple(OP_OPR, ALU_DIV);
    send_read(64'h8000_0000_0000_0000);
    send_simple(OP_LIT, 1);
    send_simple(OP_OPR, ALU_NEG);
    send_simple(OP_OPR, ALU_MOD);
    send_simple(OP_OPR, ALU_WRT);
    // Frames, out-of-range load and frame size, full stack
    send_simple(OP_INT, 3);
    send(OP_LOD, 4'hF, 32'hFFFF_FFFF, $urandom, '1);
    send_simple(OP_LEV, 0);
    send_simple(OP_INT, STACK_DEPTH - 2);
    send_simple(OP_LIT, 7);
    send_simple(OP_LEV, 0);
    send_simple(OP_OPR, 21);
    send_simple(OP_RET, 0);
    send_simple(4'hF, 32'hFFFF_FFFF);

    // Random instruction streams, with and without idling
    for (int i = 0; i < 1800; i++) begin
      if (i % 300 == 150) no_idle = 1;
      if (i % 300 == 0) no_idle = 0;
      if (i == 600) begin
        s_axis_tvalid_i = 0;
        drain();
        @(negedge clk_i);
      end
      if (i == 1000) hold_req = 1;
      send_random();
    end
    s_axis_tvalid_i = 0;

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[files.f]
rtl/pscm_pkg.sv
rtl/pscm_ram.sv
rtl/pcode_stack_machine_step_unit.sv
rtl/pscm_checker.sv
bench/tb_pcode_stack_machine_step_unit.sv
